// ===== sv/ltu_pkg.sv =====
// ----------------------------------------------------------------------------
// ltu_pkg
// Shared types, codes and the CP1252 high-range table for the text
// transcoder.
// ----------------------------------------------------------------------------
package ltu_pkg;

    // Input operation codes
    localparam logic [1:0] OP_UNICODE = 2'd0;
    localparam logic [1:0] OP_CP1252  = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    // Result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_PARA = 1'b1;

    // Control code points of interest
    localparam logic [15:0] CP_CR        = 16'h000D;
    localparam logic [15:0] CP_CELL_MARK = 16'h0007;
    localparam logic [15:0] CP_PAGE      = 16'h000C;
    localparam logic [15:0] CP_VTAB      = 16'h000B;
    localparam logic [15:0] CP_SPACE     = 16'h0020;
    localparam logic [15:0] CP_TAB       = 16'h0009;
    localparam logic [15:0] CP_LF        = 16'h000A;
    localparam logic [15:0] CP_2BYTE_MIN = 16'h0080;
    localparam logic [15:0] CP_3BYTE_MIN = 16'h0800;

    // One unit of work for the back end: 1 to 3 result bytes
    typedef struct packed {
        logic            kind;
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } ltu_job_t;

    // Map a CP1252 byte to its code point
    function automatic logic [15:0] cp1252_map(input logic [7:0] b);
        logic [15:0] cp;
        begin
            case (b)
                8'h80: cp = 16'h20AC;
                8'h82: cp = 16'h201A;
                8'h83: cp = 16'h0192;
                8'h84: cp = 16'h201E;
                8'h85: cp = 16'h2026;
                8'h86: cp = 16'h2020;
                8'h87: cp = 16'h2021;
                8'h88: cp = 16'h02C6;
                8'h89: cp = 16'h2030;
                8'h8A: cp = 16'h0160;
                8'h8B: cp = 16'h2039;
                8'h8C: cp = 16'h0152;
                8'h8E: cp = 16'h017D;
                8'h91: cp = 16'h2018;
                8'h92: cp = 16'h2019;
                8'h93: cp = 16'h201C;
                8'h94: cp = 16'h201D;
                8'h95: cp = 16'h2022;
                8'h96: cp = 16'h2013;
                8'h97: cp = 16'h2014;
                8'h98: cp = 16'h02DC;
                8'h99: cp = 16'h2122;
                8'h9A: cp = 16'h0161;
                8'h9B: cp = 16'h203A;
                8'h9C: cp = 16'h0153;
                8'h9E: cp = 16'h017E;
                8'h9F: cp = 16'h0178;
                default: cp = {8'h00, b};
            endcase
            return cp;
        end
    endfunction

endpackage

// ===== sv/ltu_front.sv =====
// ----------------------------------------------------------------------------
// ltu_front
// Accepts code units, maps and filters them, tracks paragraph state and
// writes UTF-8 jobs into the job queue.
// ----------------------------------------------------------------------------
module ltu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       opcode,
    input  logic [15:0]      code_unit,
    input  logic             q_full,
    output logic             q_wr,
    output ltu_pkg::ltu_job_t q_wr_job
);
    import ltu_pkg::*;

    logic        has_text_reg;
    logic        has_text_next;
    logic        accept;
    logic [15:0] cp;
    logic [15:0] cp_fix;
    logic        para_end;
    logic        is_text;
    ltu_job_t    job;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Map the unit to a code point
    always_comb
    begin
        if (opcode == OP_CP1252)
            cp = cp1252_map(code_unit[7:0]);
        else
            cp = code_unit;
        cp_fix = (cp == CP_VTAB) ? CP_LF : cp;
    end

    // Classify the transaction and build the job
    always_comb
    begin
        para_end = 1'b0;
        is_text  = 1'b0;
        case (opcode)
            OP_FLUSH:
            begin
                para_end = 1'b1;
            end
            OP_UNICODE, OP_CP1252:
            begin
                if (cp == CP_CR || cp == CP_CELL_MARK || cp == CP_PAGE)
                    para_end = 1'b1;
                else if (cp_fix >= CP_SPACE || cp_fix == CP_TAB || cp_fix == CP_LF)
                    is_text = 1'b1;
            end
            default:
            begin
                para_end = 1'b0;
            end
        endcase

        job       = '0;
        job.kind  = KIND_TEXT;
        if (para_end)
        begin
            job.kind = KIND_PARA;
            job.cnt  = 2'd1;
        end
        else if (cp_fix < CP_2BYTE_MIN)
        begin
            job.cnt      = 2'd1;
            job.bytes[0] = cp_fix[7:0];
        end
        else if (cp_fix < CP_3BYTE_MIN)
        begin
            job.cnt      = 2'd2;
            job.bytes[0] = {3'b110, cp_fix[10:6]};
            job.bytes[1] = {2'b10, cp_fix[5:0]};
        end
        else
        begin
            job.cnt      = 2'd3;
            job.bytes[0] = {4'b1110, cp_fix[15:12]};
            job.bytes[1] = {2'b10, cp_fix[11:6]};
            job.bytes[2] = {2'b10, cp_fix[5:0]};
        end
    end

    // Emit each text job, and a marker only when the paragraph holds text
    always_comb
    begin
        has_text_next = has_text_reg;
        q_wr          = 1'b0;
        if (accept)
        begin
            if (para_end)
            begin
                q_wr          = has_text_reg;
                has_text_next = 1'b0;
            end
            else if (is_text)
            begin
                q_wr          = 1'b1;
                has_text_next = 1'b1;
            end
        end
    end

    assign q_wr_job = job;

    // Hold paragraph state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            has_text_reg <= 1'b0;
        else
            has_text_reg <= has_text_next;
    end

endmodule

// ===== sv/ltu_queue.sv =====
// ----------------------------------------------------------------------------
// ltu_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
module ltu_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  ltu_pkg::ltu_job_t wr_job,
    input  logic              rd,
    output ltu_pkg::ltu_job_t rd_job,
    output logic              q_full,
    output logic              q_empty
);
    import ltu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ltu_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== sv/ltu_back.sv =====
// ----------------------------------------------------------------------------
// ltu_back
// Walks the head job byte by byte into the result register.
// ----------------------------------------------------------------------------
module ltu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ltu_pkg::ltu_job_t head_job,
    input  logic              q_empty,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output logic              kind,
    output logic [7:0]        text_byte,
    output logic              last
);
    import ltu_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       is_last;

    assign load    = (!out_valid_reg || pop) && !q_empty;
    assign is_last = (idx_reg == head_job.cnt - 2'd1);
    assign q_rd    = load && is_last;

    // Advance the byte index and result valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head_job.kind;
            byte_reg <= head_job.bytes[idx_reg];
            last_reg <= is_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = kind_reg;
    assign text_byte = byte_reg;
    assign last      = last_reg;

endmodule

// ===== sv/legacy_text_to_utf8_paragraphs_core.sv =====
// ----------------------------------------------------------------------------
// legacy_text_to_utf8_paragraphs_core
// CP1252 / 16-bit unit to UTF-8 transcoder with paragraph markers.
// ----------------------------------------------------------------------------
// The block takes one code unit per cycle while full is low and writes each
// unit that yields output into a job queue of QUEUE_DEPTH entries; dropped
// units and empty paragraph ends leave nothing. The back end sends one result
// per cycle from the head job while pop takes each result, so an item yields
// 1, 2 or 3 results according to its UTF-8 length; the result port is a single
// output register, which sets the sustained rate at one result per cycle while
// pop stays high. Input sees full only while the queue holds QUEUE_DEPTH jobs.
// An item's first result goes into a queue slot, then the output register.
module legacy_text_to_utf8_paragraphs_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [15:0] code_unit,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  text_byte,
    output logic        last
);
    import ltu_pkg::*;

    ltu_job_t q_wr_job;
    ltu_job_t head_job;
    logic     q_wr;
    logic     q_rd;
    logic     q_full;
    logic     q_empty;

    ltu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .code_unit (code_unit),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wr_job  (q_wr_job)
    );

    ltu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_job  (q_wr_job),
        .rd      (q_rd),
        .rd_job  (head_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    ltu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .text_byte (text_byte),
        .last      (last)
    );

endmodule

// ===== sv/ltu_checker.sv =====
// ----------------------------------------------------------------------------
// ltu_checker
// Port-level checks on the transcoder result stream.
// ----------------------------------------------------------------------------
module ltu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        kind,
    input logic [7:0]  text_byte,
    input logic        last
);
    import ltu_pkg::*;

    logic prev_marker_reg;
    logic take;

    assign take = pop && !empty;

    // Remember whether the last taken transaction was a paragraph marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_marker_reg <= 1'b0;
        else if (take)
            prev_marker_reg <= (kind == KIND_PARA);
    end

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(kind) && $stable(text_byte) && $stable(last))
        else $error("result changed while waiting");

    // A marker carries a zero byte and closes its transaction group
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == KIND_PARA |-> text_byte == 8'h00 && last)
        else $error("bad paragraph marker");

    // A UTF-8 lead byte is never the final byte
    a_lead: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == KIND_TEXT && text_byte[7:6] == 2'b11 |-> !last)
        else $error("lead byte marked last");

    // An ASCII byte is always complete
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == KIND_TEXT && !text_byte[7] |-> last)
        else $error("ascii byte not last");

    // Two paragraph markers never follow each other
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        take && kind == KIND_PARA |-> !prev_marker_reg)
        else $error("empty paragraph emitted");

endmodule

bind legacy_text_to_utf8_paragraphs_core ltu_checker u_ltu_checker (.*);
